@@ rtl/core/sls_pkg.sv @@
// Shared types and constants for the scanline sprite select and sort block.
// No dependencies; imported by sls_cell and sprite_line_select_sort.
package sls_pkg;

  localparam int unsigned ROW_SPAN_TALL  = 16;
  localparam int unsigned ROW_SPAN_SHORT = 8;

  localparam int unsigned ATTR_PRIORITY = 7;
  localparam int unsigned ATTR_YFLIP    = 6;
  localparam int unsigned ATTR_XFLIP    = 5;
  localparam int unsigned ATTR_PALETTE  = 4;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] x;
    logic [7:0] tile;
    logic [3:0] flags;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic rotate;
  } cell_ctl_t;

endpackage

@@ rtl/core/sls_cell.sv @@
// One slot of the sorted sprite chain: holds an entry, takes part in the
// ordered insertion and in the rotation used for readout. Uses sls_pkg.
module sls_cell (
  input  logic               clk,
  input  sls_pkg::cell_ctl_t ctl,
  input  sls_pkg::entry_t    new_entry,
  input  logic               occ,
  input  logic               left_occ,
  input  logic               left_disp,
  input  sls_pkg::entry_t    left_entry,
  input  sls_pkg::entry_t    right_entry,
  output logic               disp,
  output sls_pkg::entry_t    entry
);
  import sls_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;
  logic   take;

  assign disp = occ && (new_entry.x < entry_r.x);
  assign take = disp || (!occ && left_occ);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.insert && take) begin
      entry_nxt = left_disp ? left_entry : new_entry;
    end else if (ctl.rotate) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

@@ rtl/core/sprite_line_select_sort.sv @@
// Top level of the scanline sprite select and sort block.
// Depends on sls_pkg and sls_cell.
//
// Usage: sprite attribute entries arrive on the in_ channel, one beat per
// entry in memory order. in_first_entry clears the list before the entry is
// evaluated. A selected entry is inserted into a chain of MAX_SELECTED cells
// kept sorted by X; equal X keeps arrival order, a full chain drops it.
// Each entry beat is handled at its accepting edge, where the range compare
// and the chain insert happen. After a beat with in_last_entry the block
// reads the chain out on the out_ channel by rotating it one cell per beat,
// and the chain is whole again afterward. An empty list yields one marker
// beat with out_found low. in_ready stays low during readout; the output
// register lets the next entry be taken while the final result still waits.
// A stalled receiver holds the output register and pauses the rotation.
// cfg_ sets tall sprites; cfg_ready is always high. Reset clears the count,
// the mode and all valid flags; the cells need no reset.
module sprite_line_select_sort #(
  parameter int unsigned MAX_SELECTED = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_tall_sprites,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_first_entry,
  input  logic       in_last_entry,
  input  logic [7:0] in_line,
  input  logic [7:0] in_sprite_y,
  input  logic [7:0] in_sprite_x,
  input  logic [7:0] in_tile_number,
  input  logic [7:0] in_attributes,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_found,
  output logic [7:0] out_y,
  output logic [7:0] out_x,
  output logic [7:0] out_tile,
  output logic       out_behind_background,
  output logic       out_flip_vertical,
  output logic       out_flip_horizontal,
  output logic       out_palette_select,
  output logic       out_final_result
);
  import sls_pkg::*;

  localparam int unsigned CW = $clog2(MAX_SELECTED + 1);
  localparam logic        ST_IDLE = 1'b0;
  localparam logic        ST_EMIT = 1'b1;

  logic          state_r, state_nxt;
  logic          tall_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] count_eff;

  logic          in_fire;
  logic          out_load;
  logic          match;
  logic          do_insert;
  logic signed [9:0] line_s, top_s, bottom_s;

  entry_t        new_entry;
  cell_ctl_t     ctl;
  entry_t        cell_entry [MAX_SELECTED];
  logic          cell_disp  [MAX_SELECTED];
  logic          cell_occ   [MAX_SELECTED];

  logic          out_valid_r, out_valid_nxt;
  logic          found_r, final_r;
  entry_t        out_entry_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;

  assign count_eff = in_first_entry ? '0 : count_r;
  assign line_s    = $signed({2'b00, in_line});
  assign top_s     = $signed({2'b00, in_sprite_y}) - 10'sd16;
  assign bottom_s  = tall_r ? $signed({2'b00, in_sprite_y})
                            : $signed({2'b00, in_sprite_y}) - 10'sd8;
  assign match     = (line_s >= top_s) && (line_s < bottom_s);
  assign do_insert = in_fire && match && (count_eff < CW'(MAX_SELECTED));

  assign new_entry.y     = in_sprite_y;
  assign new_entry.x     = in_sprite_x;
  assign new_entry.tile  = in_tile_number;
  assign new_entry.flags = in_attributes[ATTR_PRIORITY:ATTR_PALETTE];

  assign out_load   = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign ctl.insert = do_insert;
  assign ctl.rotate = out_load && (count_r != '0);

  for (genvar i = 0; i < MAX_SELECTED; i++) begin : g_cell
    logic   l_occ, l_disp;
    entry_t l_entry, r_entry;

    assign cell_occ[i] = (CW'(i) < count_eff);

    if (i == 0) begin : g_head
      assign l_occ   = 1'b1;
      assign l_disp  = 1'b0;
      assign l_entry = new_entry;
    end else begin : g_body
      assign l_occ   = cell_occ[i-1];
      assign l_disp  = cell_disp[i-1];
      assign l_entry = cell_entry[i-1];
    end

    if (i == MAX_SELECTED - 1) begin : g_tail
      assign r_entry = cell_entry[0];
    end else begin : g_mid
      assign r_entry = (CW'(i + 1) == count_r) ? cell_entry[0] : cell_entry[i+1];
    end

    sls_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .new_entry   (new_entry),
      .occ         (cell_occ[i]),
      .left_occ    (l_occ),
      .left_disp   (l_disp),
      .left_entry  (l_entry),
      .right_entry (r_entry),
      .disp        (cell_disp[i]),
      .entry       (cell_entry[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          count_nxt = do_insert ? count_eff + CW'(1) : count_eff;
          idx_nxt   = '0;
          if (in_last_entry) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          idx_nxt = idx_r + CW'(1);
          if ((count_r == '0) || (idx_r == count_r - CW'(1))) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tall_r      <= 1'b0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        tall_r <= cfg_tall_sprites;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (count_r == '0) begin
        found_r     <= 1'b0;
        final_r     <= 1'b1;
        out_entry_r <= '0;
      end else begin
        found_r     <= 1'b1;
        final_r     <= (idx_r == count_r - CW'(1));
        out_entry_r <= cell_entry[0];
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_found             = found_r;
  assign out_y                 = out_entry_r.y;
  assign out_x                 = out_entry_r.x;
  assign out_tile              = out_entry_r.tile;
  assign out_behind_background = out_entry_r.flags[3];
  assign out_flip_vertical     = out_entry_r.flags[2];
  assign out_flip_horizontal   = out_entry_r.flags[1];
  assign out_palette_select    = out_entry_r.flags[0];
  assign out_final_result      = final_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SELECTED))
    else $error("selected count beyond chain depth");

  a_last_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_last_entry) |=> (state_r == ST_EMIT))
    else $error("last entry did not start readout");

  a_marker_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> out_final_result)
    else $error("empty marker without final flag");

  a_no_rotate_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rotate |-> (state_r == ST_EMIT) && !ctl.insert)
    else $error("chain rotated outside readout");

endmodule

@@ sim/sprite_line_select_sort_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for sprite_line_select_sort: drives sprite entries and
// checks every emitted sprite beat against an in-bench selection/sort predictor.
// Depends on sls_pkg and the RTL of sprite_line_select_sort.
module sprite_line_select_sort_tb;
  import sls_pkg::*;

  localparam int MAX_SEL     = 10;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    bit         first;
    bit         last;
    logic [7:0] line;
    logic [7:0] y;
    logic [7:0] x;
    logic [7:0] tile;
    logic [7:0] attr;
    bit         drain_first;
  } oam_entry_t;

  typedef struct packed {
    logic       found;
    logic [7:0] y;
    logic [7:0] x;
    logic [7:0] tile;
    logic       behind_bg;
    logic       vflip;
    logic       hflip;
    logic       palette;
    logic       last_of_run;
  } sprite_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_tall_sprites = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_first_entry = 1'b0;
  logic       in_last_entry = 1'b0;
  logic [7:0] in_line = 8'd0;
  logic [7:0] in_sprite_y = 8'd0;
  logic [7:0] in_sprite_x = 8'd0;
  logic [7:0] in_tile_number = 8'd0;
  logic [7:0] in_attributes = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_found;
  logic [7:0] out_y;
  logic [7:0] out_x;
  logic [7:0] out_tile;
  logic       out_behind_background;
  logic       out_flip_vertical;
  logic       out_flip_horizontal;
  logic       out_palette_select;
  logic       out_final_result;

  oam_entry_t   oam_pending[$];
  oam_entry_t   cur_entry;
  sprite_beat_t sprites_due[$];

  entry_t sel_list[MAX_SEL];
  int     sel_count = 0;
  bit     tall_mode = 1'b0;

  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int beats_seen = 0;
  int markers_seen = 0;
  int entries_taken = 0;
  int cycles = 0;

  sprite_line_select_sort #(.MAX_SELECTED(MAX_SEL)) u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_tall_sprites      (cfg_tall_sprites),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_first_entry        (in_first_entry),
    .in_last_entry         (in_last_entry),
    .in_line               (in_line),
    .in_sprite_y           (in_sprite_y),
    .in_sprite_x           (in_sprite_x),
    .in_tile_number        (in_tile_number),
    .in_attributes         (in_attributes),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_found             (out_found),
    .out_y                 (out_y),
    .out_x                 (out_x),
    .out_tile              (out_tile),
    .out_behind_background (out_behind_background),
    .out_flip_vertical     (out_flip_vertical),
    .out_flip_horizontal   (out_flip_horizontal),
    .out_palette_select    (out_palette_select),
    .out_final_result      (out_final_result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic sprite_beat_t sprite_to_beat(entry_t s, bit last_of_run);
    sprite_beat_t b;
    b.found       = 1'b1;
    b.y           = s.y;
    b.x           = s.x;
    b.tile        = s.tile;
    b.behind_bg   = s.flags[3];
    b.vflip       = s.flags[2];
    b.hflip       = s.flags[1];
    b.palette     = s.flags[0];
    b.last_of_run = last_of_run;
    return b;
  endfunction

  // Range test, stable insert by X, and readout on the last entry.
  function automatic void scan_oam_entry(oam_entry_t e);
    int           line_i;
    int           top;
    int           bottom;
    int           pos;
    entry_t       s;
    sprite_beat_t marker;
    if (e.first) sel_count = 0;
    line_i = int'(e.line);
    top    = int'(e.y) - int'(ROW_SPAN_TALL);
    bottom = tall_mode ? int'(e.y) : int'(e.y) - int'(ROW_SPAN_SHORT);
    if (line_i >= top && line_i < bottom && sel_count < MAX_SEL) begin
      s.y     = e.y;
      s.x     = e.x;
      s.tile  = e.tile;
      s.flags = {e.attr[ATTR_PRIORITY], e.attr[ATTR_YFLIP],
                 e.attr[ATTR_XFLIP], e.attr[ATTR_PALETTE]};
      pos = 0;
      while (pos < sel_count && !(s.x < sel_list[pos].x)) pos++;
      for (int k = sel_count; k > pos; k--) sel_list[k] = sel_list[k - 1];
      sel_list[pos] = s;
      sel_count++;
    end
    if (e.last) begin
      if (sel_count == 0) begin
        marker = '0;
        marker.last_of_run = 1'b1;
        sprites_due.push_back(marker);
      end else begin
        for (int i = 0; i < sel_count; i++)
          sprites_due.push_back(sprite_to_beat(sel_list[i], i + 1 == sel_count));
      end
    end
  endfunction

  function automatic string beat_str(sprite_beat_t b);
    return $sformatf("found=%0b y=%02h x=%02h tile=%02h bg=%0b vf=%0b hf=%0b pal=%0b fin=%0b",
                     b.found, b.y, b.x, b.tile, b.behind_bg, b.vflip, b.hflip,
                     b.palette, b.last_of_run);
  endfunction

  always @(posedge clk) begin : drive
    bit offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        scan_oam_entry(cur_entry);
        entries_taken++;
      end
      if (!in_valid || in_ready) begin
        offer = 1'b0;
        if (oam_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
          if (!oam_pending[0].drain_first || sprites_due.size() == 0) offer = 1'b1;
        end
        if (offer) begin
          cur_entry      = oam_pending.pop_front();
          in_first_entry <= cur_entry.first;
          in_last_entry  <= cur_entry.last;
          in_line        <= cur_entry.line;
          in_sprite_y    <= cur_entry.y;
          in_sprite_x    <= cur_entry.x;
          in_tile_number <= cur_entry.tile;
          in_attributes  <= cur_entry.attr;
        end
        in_valid <= offer;
      end
    end
  end

  always @(posedge clk) begin : watch
    sprite_beat_t got;
    sprite_beat_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.found       = out_found;
        got.y           = out_y;
        got.x           = out_x;
        got.tile        = out_tile;
        got.behind_bg   = out_behind_background;
        got.vflip       = out_flip_vertical;
        got.hflip       = out_flip_horizontal;
        got.palette     = out_palette_select;
        got.last_of_run = out_final_result;
        beats_seen++;
        if (!out_found) markers_seen++;
        if (sprites_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected sprite beat: %s", beat_str(got));
        end else begin
          want = sprites_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("sprite beat mismatch at beat %0d", beats_seen);
              $display("  expected %s", beat_str(want));
              $display("  actual   %s", beat_str(got));
            end
          end
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, sprites_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic add_entry(bit first, bit last, logic [7:0] line, logic [7:0] y,
                           logic [7:0] x, logic [7:0] tile, logic [7:0] attr,
                           bit drain_first = 1'b0);
    oam_entry_t e;
    e.first       = first;
    e.last        = last;
    e.line        = line;
    e.y           = y;
    e.x           = x;
    e.tile        = tile;
    e.attr        = attr;
    e.drain_first = drain_first;
    oam_pending.push_back(e);
  endtask

  // Y lands around the selection window of the line, wrapping at 8 bits.
  task automatic add_random_entry(logic [7:0] line, bit first, bit last, bit drain_first);
    logic [7:0] y;
    logic [7:0] x;
    y = ($urandom_range(7) == 0) ? 8'($urandom) : 8'(line + $urandom_range(27) - 2);
    x = ($urandom_range(2) == 0) ? 8'($urandom_range(3) * 64) : 8'($urandom);
    add_entry(first, last, line, y, x, 8'($urandom), 8'($urandom), drain_first);
  endtask

  task automatic queue_random_scans(int target);
    int         added;
    int         kind;
    int         len;
    logic [7:0] line;
    added = 0;
    while (added < target) begin
      kind = $urandom_range(99);
      line = 8'($urandom);
      if (kind < 70) begin
        len = ($urandom_range(11) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 14);
        for (int i = 0; i < len; i++)
          add_random_entry(line, i == 0, i == len - 1, i == 0 && $urandom_range(5) == 0);
      end else if (kind < 80) begin
        len = 1;
        add_random_entry(line, 1'b1, 1'b1, $urandom_range(5) == 0);
      end else if (kind < 90) begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) add_random_entry(line, 1'b0, i == len - 1, 1'b0);
      end else begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
          add_random_entry(8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                           1'b0);
      end
      added += len;
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (oam_pending.size() != 0 || in_valid || sprites_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_tall(bit tall);
    @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_tall_sprites <= tall;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tall_mode = tall;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    write_tall(1'b0);

    add_entry(1, 1, 8'd0,   8'd0,   8'h00, 8'h00, 8'h00);
    add_entry(1, 1, 8'd0,   8'd9,   8'hFF, 8'hFF, 8'hFF);
    add_entry(1, 1, 8'd255, 8'd255, 8'hFF, 8'hFF, 8'hFF);
    add_entry(1, 0, 8'd100, 8'd116, 8'd50, 8'd0, 8'h80);
    begin : fill_list
      logic [7:0] xs[11];
      logic [7:0] attrs[4];
      xs    = '{8'd20, 8'd50, 8'd80, 8'd20, 8'd0, 8'd255, 8'd50, 8'd10, 8'd10, 8'd30, 8'd40};
      attrs = '{8'h40, 8'h20, 8'h10, 8'h0F};
      for (int i = 0; i < 11; i++)
        add_entry(0, 0, 8'd100, 8'(116 - (i + 1) % 8), xs[i], 8'(i + 1), attrs[i % 4]);
    end
    add_entry(0, 1, 8'd100, 8'd108, 8'd1, 8'd99, 8'hF0);
    add_entry(0, 1, 8'd100, 8'd110, 8'd0, 8'd77, 8'hF0);
    add_entry(1, 0, 8'd7,   8'd15,  8'd3, 8'd1, 8'h00);
    add_entry(0, 1, 8'd7,   8'd16,  8'd3, 8'd2, 8'hA0, 1'b1);
    add_entry(0, 1, 8'd7,   8'd24,  8'd3, 8'd3, 8'h50);
    wait_drained();

    write_tall(1'b1);
    add_entry(1, 1, 8'd254, 8'd255, 8'd9, 8'd1, 8'hC0);
    add_entry(1, 0, 8'd0,   8'd1,   8'd5, 8'd2, 8'h30);
    add_entry(0, 0, 8'd0,   8'd16,  8'd5, 8'd3, 8'h90);
    add_entry(0, 1, 8'd0,   8'd17,  8'd5, 8'd4, 8'h60);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = (p == 1) ? 62 : (p == 3) ? 13 : 0;
      stall_pct = (p == 2) ? 62 : (p == 3) ? 13 : 0;
      for (int t = 0; t < 2; t++) begin
        write_tall(1'((p + t) % 2));
        queue_random_scans(28);
        wait_drained();
      end
    end

    mismatches += sprites_due.size();
    $display("Scanned %0d sprite entries, checked %0d result beats (%0d empty markers)",
             entries_taken, beats_seen, markers_seen);
    $display("Covered 8x8 and 8x16 sprites, list overflow and ties, all idle/stall mixes");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
